FILE: hw/rtl/chunk_reassembly_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunk reassembly tracker
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH
`define CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH

// expr holds at every edge
`define CRT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define CRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define CRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Types and constants shared by the chunk reassembly tracker modules.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_W     = 5;
    localparam int CHUNK_W    = 12;
    localparam int BLK_W      = 22;
    localparam int OFF_W      = 10;
    localparam int BPC        = 1024;
    localparam int MAX_CHUNKS = 4096;
    localparam int TOT_W      = 13;
    localparam int HR_W       = 6;
    localparam int CNT_W      = 11;
    localparam int FREE_W     = 6;
    localparam int CTR_W      = 32;
    localparam int WORD_W     = 32;   // bits per bitmap word
    localparam int BIT_W      = 5;
    localparam int WSEL_W     = 5;    // words per slot bitmap: 32
    localparam int MAP_AW     = SLOT_W + WSEL_W;
    localparam int MAP_DEPTH  = 1 << MAP_AW;
    localparam int FIN_AW     = 7;
    localparam int FIN_ROWS   = 1 << FIN_AW;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CHUNKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM     = 2'd1;

    typedef enum logic [1:0] {
        FN_ADD     = 2'd0,
        FN_SUGGEST = 2'd1,
        FN_CONSUME = 2'd2,
        FN_FINISH  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        STS_OK       = 4'd0,
        STS_DUP      = 4'd1,
        STS_STALE    = 4'd2,
        STS_NO_SLOT  = 4'd3,
        STS_RANGE    = 4'd4,
        STS_SUG_OPEN = 4'd5,
        STS_SUG_NEW  = 4'd6,
        STS_FULL     = 4'd7,
        STS_DONE     = 4'd8,
        STS_NONE     = 4'd9,
        STS_NOT_OPEN = 4'd10
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_CHK,
        ST_CLEAR,
        ST_ADD_WR,
        ST_FIN_WR,
        ST_SG_SLOT,
        ST_SG_WORD,
        ST_SG_HIGH,
        ST_SG_CADDR,
        ST_SG_CCHK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [CHUNK_W-1:0] chunk;
        logic [OFF_W-1:0]   off;
        logic               bad;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [BLK_W-1:0]   sugg;
        logic [CHUNK_W-1:0] chunk;
        logic [SLOT_W-1:0]  slot;
        logic [CTR_W-1:0]   dup;
        logic [CTR_W-1:0]   stale;
    } t_result;

endpackage

FILE: hw/rtl/crt_front.sv
// ----------------------------------------------------------------------------
// crt_front
// Accepts items, decodes chunk and offset and flags out-of-range indices.
// ----------------------------------------------------------------------------
module crt_front import crt_pkg::*; (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [BLK_W-1:0]   i_block,
    input  logic [CHUNK_W-1:0] i_chunk,
    input  logic [TOT_W-1:0]   i_total,
    input  logic               i_q_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [CHUNK_W-1:0] w_chunk;
    t_func              w_func;

    assign w_func  = t_func'(i_func);
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        w_chunk = (w_func == FN_ADD) ? i_block[BLK_W-1:OFF_W] : i_chunk;
        o_cmd.func  = w_func;
        o_cmd.chunk = w_chunk;
        o_cmd.off   = i_block[OFF_W-1:0];
        // only add and finish carry an index that can fall outside the image
        o_cmd.bad   = ((w_func == FN_ADD) || (w_func == FN_FINISH))
                      && ({1'b0, w_chunk} >= i_total);
    end

endmodule

FILE: hw/rtl/crt_queue.sv
// ----------------------------------------------------------------------------
// crt_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module crt_queue import crt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: hw/rtl/crt_back.sv
// ----------------------------------------------------------------------------
// crt_back
// Executes commands against the slot table and bitmaps; holds the result.
// ----------------------------------------------------------------------------
`include "chunk_reassembly_tracker_assert.svh"

module crt_back import crt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cmd             i_q_data,
    output logic             o_q_pop,
    input  logic [TOT_W-1:0] i_total,
    input  logic [HR_W-1:0]  i_headroom,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_result
);

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [SLOTS-1:0]   r_valid;
    logic [CHUNK_W-1:0] r_chunk [SLOTS];
    logic [CNT_W-1:0]   r_cnt   [SLOTS];
    logic [CTR_W-1:0]   r_dup, r_stale;

    logic [WORD_W-1:0]  fin_mem [FIN_ROWS];
    logic [FIN_ROWS-1:0] r_fin_rv;
    logic [WORD_W-1:0]  r_fin_q;
    logic               r_fin_qv;
    logic [WORD_W-1:0]  map_mem [MAP_DEPTH];
    logic [WORD_W-1:0]  r_map_q;

    logic [SLOT_W-1:0]  r_slot, r_si;
    logic [WSEL_W-1:0]  r_word;
    logic               r_fresh;
    logic [FREE_W-1:0]  r_free;
    logic [FIN_AW-1:0]  r_w;
    logic [CHUNK_W-1:0] r_high, r_c;
    logic [TOT_W-1:0]   r_e;
    t_status            r_res_status;
    logic [BLK_W-1:0]   r_res_sugg;
    logic [CHUNK_W-1:0] r_res_chunk;
    logic               r_out_valid;
    t_result            r_out;

    logic [CHUNK_W-1:0] w_key;
    logic [SLOTS-1:0]   w_match;
    logic               w_hit, w_free_any, w_cmp_any, w_hi_any, w_emit;
    logic [SLOT_W-1:0]  w_hit_idx, w_free_idx, w_cmp_idx;
    logic [BIT_W-1:0]   w_zero_idx, w_hi_idx;
    logic [WORD_W-1:0]  w_fin_word, w_map_word;
    logic               w_fin_bit_add, w_fin_bit_c, w_map_bit, w_slot_open;
    logic [TOT_W-1:0]   w_total_m1;
    logic [FIN_AW-1:0]  w_last_w;
    logic [CHUNK_W-1:0] w_idx;
    logic [CHUNK_W-1:0] w_c_next;

    logic               fin_we, map_we;
    logic [FIN_AW-1:0]  fin_raddr, fin_waddr;
    logic [MAP_AW-1:0]  map_raddr, map_waddr;
    logic [WORD_W-1:0]  fin_wdata, map_wdata;

    // ---------------- lookups ----------------
    always_comb begin
        w_key = (r_state == ST_SG_CCHK) ? r_c : r_cmd.chunk;
        w_hit = 1'b0; w_free_any = 1'b0; w_cmp_any = 1'b0;
        w_hit_idx = '0; w_free_idx = '0; w_cmp_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_chunk[i] == w_key);
            if (w_match[i]) begin
                w_hit = 1'b1; w_hit_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_any = 1'b1; w_free_idx = SLOT_W'(i);
            end
            if (r_valid[i] && (r_cnt[i] == CNT_W'(BPC))) begin
                w_cmp_any = 1'b1; w_cmp_idx = SLOT_W'(i);
            end
        end
    end

    assign w_total_m1 = i_total - TOT_W'(1);
    assign w_last_w   = w_total_m1[CHUNK_W-1:BIT_W];
    assign w_fin_word = r_fin_qv ? r_fin_q : '0;
    assign w_map_word = r_fresh ? '0 : r_map_q;
    assign w_fin_bit_add = w_fin_word[r_cmd.chunk[BIT_W-1:0]];
    assign w_fin_bit_c   = w_fin_word[r_c[BIT_W-1:0]];
    assign w_map_bit     = w_map_word[r_cmd.off[BIT_W-1:0]];
    assign w_slot_open   = r_valid[r_si] && (r_cnt[r_si] != CNT_W'(BPC));
    assign w_c_next      = (({1'b0, r_c} + TOT_W'(1)) == i_total) ? '0 : r_c + CHUNK_W'(1);

    always_comb begin
        w_zero_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!r_map_q[b]) w_zero_idx = BIT_W'(b);
        end
        w_hi_any = 1'b0;
        w_hi_idx = '0;
        w_idx    = '0;
        for (int b = 0; b < WORD_W; b++) begin
            w_idx = {r_w, BIT_W'(b)};
            if (w_fin_word[b] && ({1'b0, w_idx} < i_total) && (w_idx != '0)) begin
                w_hi_any = 1'b1; w_hi_idx = BIT_W'(b);
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_q_valid) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (r_cmd.func)
                    FN_ADD:     n_state = r_cmd.bad ? ST_EMIT : ST_ADD_CHK;
                    FN_FINISH:  n_state = r_cmd.bad ? ST_EMIT : ST_FIN_WR;
                    FN_CONSUME: n_state = ST_EMIT;
                    FN_SUGGEST: n_state = ST_SG_SLOT;
                endcase
            end
            ST_ADD_CHK: begin
                priority if (w_fin_bit_add) n_state = ST_EMIT;
                else if (w_hit)             n_state = ST_ADD_WR;
                else if (w_free_any)        n_state = ST_CLEAR;
                else                        n_state = ST_EMIT;
            end
            ST_CLEAR:  if (r_word == '1) n_state = ST_ADD_WR;
            ST_ADD_WR: n_state = ST_EMIT;
            ST_FIN_WR: n_state = ST_EMIT;
            ST_SG_SLOT: begin
                priority if (w_slot_open) n_state = ST_SG_WORD;
                else if (r_si == '1)      n_state = ST_SG_HIGH;
                else                      n_state = ST_SG_SLOT;
            end
            ST_SG_WORD: begin
                priority if (r_map_q != '1) n_state = ST_EMIT;
                else if (r_word == '1)      n_state = (r_si == '1) ? ST_SG_HIGH : ST_SG_SLOT;
                else                        n_state = ST_SG_WORD;
            end
            ST_SG_HIGH:  if (r_w == w_last_w) n_state = ST_SG_CADDR;
            ST_SG_CADDR: n_state = ST_SG_CCHK;
            ST_SG_CCHK: begin
                if ((!w_fin_bit_c && !w_hit) || ((r_e + TOT_W'(1)) == i_total))
                    n_state = ST_EMIT;
                else
                    n_state = ST_SG_CADDR;
            end
            ST_EMIT: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
        endcase
    end

    // ---------------- memory controls ----------------
    always_comb begin
        o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
        w_emit    = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
        fin_raddr = r_cmd.chunk[CHUNK_W-1:BIT_W];
        fin_we    = 1'b0;
        fin_waddr = r_cmd.chunk[CHUNK_W-1:BIT_W];
        fin_wdata = w_fin_word | (WORD_W'(1) << r_cmd.chunk[BIT_W-1:0]);
        map_raddr = {w_hit_idx, r_cmd.off[OFF_W-1:BIT_W]};
        map_we    = 1'b0;
        map_waddr = {r_slot, r_cmd.off[OFF_W-1:BIT_W]};
        map_wdata = w_map_word | (WORD_W'(1) << r_cmd.off[BIT_W-1:0]);
        unique case (r_state)
            ST_SG_SLOT:  begin
                fin_raddr = '0;
                map_raddr = {r_si, WSEL_W'(0)};
            end
            ST_SG_WORD:  begin
                fin_raddr = '0;
                map_raddr = {r_si, r_word + WSEL_W'(1)};
            end
            ST_SG_HIGH:  fin_raddr = r_w + FIN_AW'(1);
            ST_SG_CADDR: fin_raddr = r_c[CHUNK_W-1:BIT_W];
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = {r_slot, r_word};
                map_wdata = '0;
            end
            ST_ADD_WR: map_we = !w_map_bit;
            ST_FIN_WR: fin_we = 1'b1;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_fin_rv    <= '0;
            r_dup       <= '0;
            r_stale     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            if (fin_we) r_fin_rv[fin_waddr] <= 1'b1;
            if (w_emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_ADD_CHK: begin
                    if (w_fin_bit_add) r_stale <= r_stale + CTR_W'(1);
                    else if (!w_hit && w_free_any) begin
                        r_valid[w_free_idx] <= 1'b1;
                        r_cnt[w_free_idx]   <= '0;
                    end
                end
                ST_ADD_WR: begin
                    if (w_map_bit) r_dup <= r_dup + CTR_W'(1);
                    else r_cnt[r_slot] <= r_cnt[r_slot] + CNT_W'(1);
                end
                ST_FIN_WR: if (w_hit) r_valid[w_hit_idx] <= 1'b0;
                default: ;
            endcase
        end
    end

    // ---------------- memories and payload ----------------
    always_ff @(posedge i_clk) begin
        if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
        r_fin_q  <= fin_mem[fin_raddr];
        r_fin_qv <= r_fin_rv[fin_raddr];
        if (map_we) map_mem[map_waddr] <= map_wdata;
        r_map_q <= map_mem[map_raddr];

        if (o_q_pop) r_cmd <= i_q_data;

        unique case (r_state)
            ST_DISPATCH: begin
                r_res_sugg   <= '0;
                r_res_chunk  <= '0;
                r_slot       <= '0;
                r_si         <= '0;
                r_free       <= '0;
                r_res_status <= STS_RANGE;
                if (r_cmd.func == FN_CONSUME) begin
                    r_res_status <= w_cmp_any ? STS_OK : STS_NONE;
                    if (w_cmp_any) begin
                        r_res_chunk <= r_chunk[w_cmp_idx];
                        r_slot      <= w_cmp_idx;
                    end
                end
            end
            ST_ADD_CHK: begin
                priority if (w_fin_bit_add) r_res_status <= STS_STALE;
                else if (w_hit) begin
                    r_slot  <= w_hit_idx;
                    r_fresh <= 1'b0;
                end else if (w_free_any) begin
                    r_slot              <= w_free_idx;
                    r_chunk[w_free_idx] <= r_cmd.chunk;
                    r_word              <= '0;
                    r_fresh             <= 1'b1;
                end else r_res_status <= STS_NO_SLOT;
            end
            ST_CLEAR:  r_word <= r_word + WSEL_W'(1);
            ST_ADD_WR: r_res_status <= w_map_bit ? STS_DUP : STS_OK;
            ST_FIN_WR: begin
                r_res_status <= w_hit ? STS_OK : STS_NOT_OPEN;
                if (w_hit) r_slot <= w_hit_idx;
            end
            ST_SG_SLOT: begin
                if (!r_valid[r_si]) r_free <= r_free + FREE_W'(1);
                if (w_slot_open) r_word <= '0;
                else r_si <= r_si + SLOT_W'(1);
                r_w    <= '0;
                r_high <= '0;
            end
            ST_SG_WORD: begin
                priority if (r_map_q != '1) begin
                    r_res_status <= STS_SUG_OPEN;
                    r_res_sugg   <= {r_chunk[r_si], r_word, w_zero_idx};
                end else if (r_word == '1) r_si <= r_si + SLOT_W'(1);
                else r_word <= r_word + WSEL_W'(1);
                r_w    <= '0;
                r_high <= '0;
            end
            ST_SG_HIGH: begin
                if (w_hi_any) r_high <= {r_w, w_hi_idx};
                r_w <= r_w + FIN_AW'(1);
                r_c <= w_hi_any ? {r_w, w_hi_idx} : r_high;
                r_e <= '0;
            end
            ST_SG_CCHK: begin
                priority if (!w_fin_bit_c && !w_hit) begin
                    if (r_free >= i_headroom) begin
                        r_res_status <= STS_SUG_NEW;
                        r_res_sugg   <= {r_c, OFF_W'(0)};
                    end else r_res_status <= STS_FULL;
                end else if ((r_e + TOT_W'(1)) == i_total) r_res_status <= STS_DONE;
                else begin
                    r_e <= r_e + TOT_W'(1);
                    r_c <= w_c_next;
                end
            end
            default: ;
        endcase

        if (w_emit) begin
            r_out.status <= r_res_status;
            r_out.sugg   <= r_res_sugg;
            r_out.chunk  <= r_res_chunk;
            r_out.slot   <= r_slot;
            r_out.dup    <= r_dup;
            r_out.stale  <= r_stale;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `CRT_ASSERT_ALWAYS(a_cam_unique, $onehot0(w_match), "chunk open in two slots")
    `CRT_ASSERT_IMPL(a_add_slot_live, r_state == ST_ADD_WR, r_valid[r_slot], "add to free slot")
    `CRT_ASSERT_IMPL(a_sg_word_open, r_state == ST_SG_WORD, w_slot_open, "scan of closed slot")
    `CRT_ASSERT_NEXT(a_emit_loads, w_emit, r_out_valid && (r_state == ST_IDLE), "result lost")

endmodule

FILE: hw/rtl/chunk_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker
// Slot-pool tracker for reassembling an image sent as chunks of 1024 blocks.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel (tuser = function, tdata = block
// and chunk) and every item yields exactly one result on m_axis (tuser =
// status, tdata = suggested block, chunk, slot and both counters).
// Settings are written on the cfg channel, which is always ready; the user
// must write them only while the block is idle; the block does not check it.
// A two-entry queue lets the input keep accepting while the engine works or a
// result waits; the result register holds its value until m_axis_tready, and
// the engine stalls behind it. Consume or an out-of-range index goes from
// dispatch to emit; finish writes the finished map; add checks the finished
// map and slots and emits directly for a finished chunk or no free slot, else
// writes the bitmap, first clearing a newly allocated slot's 32-word bitmap one
// word a cycle. Suggest walks the slots one per cycle and stops inside the
// first open slot's bitmap; else it walks the finished map one 32-bit row a
// cycle, then checks candidate chunks in turn. One item is handled at a time.
// Reset empties all slots, zeroes counters and marks every finished-map row
// as unwritten, so no clearing pass is needed; the engine is ready at once.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker import crt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // block[21:0], chunk[33:22], zero pad
    input  logic [1:0]           s_axis_tuser,   // func[1:0]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata,   // suggested_block[21:0], chunk_out[33:22],
                                                 // slot[38:34], duplicate_count[70:39],
                                                 // stale_count[102:71], zero pad
    output logic [3:0]           m_axis_tuser,   // status[3:0]
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOT_W-1:0]     i_cfg_data
);

    logic [TOT_W-1:0] r_total;
    logic [HR_W-1:0]  r_headroom;
    logic [TOT_W-1:0] w_total;
    logic             w_push, w_q_full, w_q_valid, w_pop;
    t_cmd             w_cmd, w_q_data;
    t_result          w_res;

    assign o_cfg_ready = 1'b1;

    // hold the settings; writes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOT_W'(MAX_CHUNKS);
            r_headroom <= HR_W'(7);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TOTAL_CHUNKS) r_total <= i_cfg_data;
            if (i_cfg_index == CFG_HEADROOM)     r_headroom <= i_cfg_data[HR_W-1:0];
        end
    end

    // clamp the chunk total into 1 .. MAX_CHUNKS
    always_comb begin
        priority if (r_total == '0)             w_total = TOT_W'(1);
        else if (r_total > TOT_W'(MAX_CHUNKS))  w_total = TOT_W'(MAX_CHUNKS);
        else                                    w_total = r_total;
    end

    crt_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tuser),
        .i_block  (s_axis_tdata[BLK_W-1:0]),
        .i_chunk  (s_axis_tdata[BLK_W+CHUNK_W-1:BLK_W]),
        .i_total  (w_total),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    crt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_data)
    );

    crt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_pop),
        .i_total     (w_total),
        .i_headroom  (r_headroom),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_res)
    );

    assign m_axis_tuser = w_res.status;
    assign m_axis_tdata = {1'b0, w_res.stale, w_res.dup, w_res.slot, w_res.chunk, w_res.sugg};

endmodule
